[design/bsfd_pkg.sv]
// ----------------------------------------------------------------------------
// bsfd_pkg
// Shared types and constants for the byte-stuffed frame deframer.
// ----------------------------------------------------------------------------
package bsfd_pkg;

	// Frame size limit, counted in stored bytes including both framing bytes
	localparam int unsigned MAX_FRAME = 2048;
	localparam int unsigned CNT_W     = $clog2(MAX_FRAME + 1);

	// Fixed field widths
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned OFF_W     = 11;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned CFG_IDX_W = 8;

	// Width wide enough for both the count and header length plus overhead
	localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W + 1 : LEN_W + 1;

	// Stored frame layout: positions within the frame
	localparam int unsigned POS_LEN_HI = 1;
	localparam int unsigned POS_LEN_LO = 2;
	localparam int unsigned POS_MSG_ID = 3;
	localparam int unsigned POS_PARAM  = 4;
	localparam int unsigned HDR_BYTES  = 5;
	// Leading framing byte, four header bytes, closing framing byte
	localparam int unsigned FRAME_OVERHEAD = 6;

	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [OFF_W-1:0]     offset_t;
	typedef logic [LEN_W-1:0]     length_t;
	typedef logic [CNT_W-1:0]     count_t;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;

	// Result item kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAMING_BYTE         = 8'd0,
		REG_ESCAPE_BYTE          = 8'd1,
		REG_ESCAPED_FRAMING_CODE = 8'd2,
		REG_ESCAPED_ESCAPE_CODE  = 8'd3
	} cfg_reg_t;

	// Register reset values
	localparam byte_t RST_FRAMING_BYTE         = 8'd126;
	localparam byte_t RST_ESCAPE_BYTE          = 8'd125;
	localparam byte_t RST_ESCAPED_FRAMING_CODE = 8'd94;
	localparam byte_t RST_ESCAPED_ESCAPE_CODE  = 8'd93;

	// Parser stage, one-hot
	typedef enum logic [3:0] {
		STG_IDLE = 4'b0001,
		STG_OPEN = 4'b0010,
		STG_ESC  = 4'b0100,
		STG_BODY = 4'b1000
	} stage_t;

endpackage

[design/bsfd_intf.sv]
// ----------------------------------------------------------------------------
// bsfd channel interfaces
// Valid/ready channels for received bytes, result items and register writes.
// ----------------------------------------------------------------------------

// Received raw bytes
interface bsfd_rx_if;
	logic              valid;
	logic              ready;
	bsfd_pkg::byte_t   rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// Deframed result items
interface bsfd_res_if;
	logic              valid;
	logic              ready;
	logic              item_kind;
	bsfd_pkg::byte_t   payload_byte;
	bsfd_pkg::offset_t payload_offset;
	bsfd_pkg::byte_t   message_id;
	bsfd_pkg::byte_t   message_param;
	bsfd_pkg::length_t payload_length;
	logic              frame_ok;

	modport source (output valid, output item_kind, output payload_byte,
		output payload_offset, output message_id, output message_param,
		output payload_length, output frame_ok, input ready);
	modport sink (input valid, input item_kind, input payload_byte,
		input payload_offset, input message_id, input message_param,
		input payload_length, input frame_ok, output ready);
endinterface

// Register writes
interface bsfd_cfg_if;
	logic                 valid;
	logic                 ready;
	bsfd_pkg::cfg_index_t index;
	bsfd_pkg::byte_t      data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[design/byte_stuffed_frame_deframer_core.sv]
// ----------------------------------------------------------------------------
// byte_stuffed_frame_deframer_core
// Unstuffs received serial bytes, parses the frame header and streams payload
// bytes out, with an end-of-frame verdict on every framing byte.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Content
//  --------+-----+-------------------------------------------------------------
//  rx      | in  | rx_byte, one raw byte per transaction
//  res     | out | item_kind, payload_byte/offset, header fields, frame_ok
//  cfg     | in  | index, data: framing, escape and escape code registers
//
// One byte per cycle sustained while res is ready. A received byte lands in
// an input register and goes through the parser into the result register,
// which drives res valid. The input register also acts as a skid stage: rx
// is taken while a result waits, and stalls only when both registers are full.
// Reset clears the parser to idle and loads the register defaults; no clearing
// pass. cfg is always ready.
//
module byte_stuffed_frame_deframer_core (
	input logic        clk,
	input logic        arst_n,
	bsfd_rx_if.sink    rx,
	bsfd_res_if.source res,
	bsfd_cfg_if.sink   cfg
);
	import bsfd_pkg::*;

	// Configuration registers
	byte_t framing_q, escape_q, esc_framing_q, esc_escape_q;

	// Input register
	logic  valid_s1;
	byte_t byte_s1;

	// Parser state
	stage_t  stage_q;
	count_t  cnt_q;
	length_t len_q;
	byte_t   id_q, param_q;

	// Result register
	logic    out_valid_q;
	logic    kind_q, ok_q;
	byte_t   obyte_q;
	offset_t off_q;
	byte_t   oid_q, oparam_q;
	length_t olen_q;

	logic advance;

	// Next-state and result of the parser
	stage_t  stage_n;
	count_t  cnt_n, cnt_inc, pos;
	length_t len_n;
	byte_t   id_n, param_n, val;
	logic    emit, kind_n, ok_n, take;
	byte_t   obyte_n;
	offset_t off_n;

	// Handshakes
	assign cfg.ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || res.ready);
	assign rx.ready  = !valid_s1 || advance;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framing_q     <= RST_FRAMING_BYTE;
			escape_q      <= RST_ESCAPE_BYTE;
			esc_framing_q <= RST_ESCAPED_FRAMING_CODE;
			esc_escape_q  <= RST_ESCAPED_ESCAPE_CODE;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAMING_BYTE:         framing_q     <= cfg.data;
				REG_ESCAPE_BYTE:          escape_q      <= cfg.data;
				REG_ESCAPED_FRAMING_CODE: esc_framing_q <= cfg.data;
				REG_ESCAPED_ESCAPE_CODE:  esc_escape_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Parser: unstuffing, header capture, verdict
	always_comb begin
		stage_n = stage_q;
		cnt_n   = cnt_q;
		len_n   = len_q;
		id_n    = id_q;
		param_n = param_q;
		emit    = 1'b0;
		kind_n  = KIND_DATA;
		ok_n    = 1'b0;
		obyte_n = '0;
		off_n   = '0;
		take    = 1'b0;
		val     = byte_s1;
		cnt_inc = cnt_q + count_t'(1);
		pos     = (stage_q == STG_OPEN) ? cnt_inc : cnt_q;

		if (byte_s1 == framing_q) begin
			// Framing byte: close the frame, give the verdict, open the next
			emit    = 1'b1;
			kind_n  = KIND_END;
			ok_n    = (cnt_q < count_t'(MAX_FRAME))
				&& (cnt_inc >= count_t'(FRAME_OVERHEAD))
				&& (CMP_W'(cnt_inc) == CMP_W'(len_q) + CMP_W'(FRAME_OVERHEAD));
			stage_n = STG_OPEN;
			cnt_n   = '0;
			len_n   = '0;
			id_n    = '0;
			param_n = '0;
		end else if (stage_q != STG_IDLE && cnt_q < count_t'(MAX_FRAME)) begin
			if (stage_q == STG_ESC) begin
				// Unknown code: dropped, stay in escape
				if (byte_s1 == esc_framing_q) begin
					val  = framing_q;
					take = 1'b1;
				end else if (byte_s1 == esc_escape_q) begin
					val  = escape_q;
					take = 1'b1;
				end
			end else if (byte_s1 == escape_q) begin
				stage_n = STG_ESC;
				cnt_n   = pos;
			end else begin
				take = 1'b1;
			end

			if (take) begin
				// pos stays below the limit here, so the count never wraps
				cnt_n   = pos + count_t'(1);
				stage_n = STG_BODY;
				if (pos == count_t'(POS_LEN_HI)) begin
					len_n = {val, len_q[BYTE_W-1:0]};
				end else if (pos == count_t'(POS_LEN_LO)) begin
					len_n = {len_q[LEN_W-1:BYTE_W], val};
				end else if (pos == count_t'(POS_MSG_ID)) begin
					id_n = val;
				end else if (pos == count_t'(POS_PARAM)) begin
					param_n = val;
				end else if (pos >= count_t'(HDR_BYTES)) begin
					emit    = 1'b1;
					obyte_n = val;
					off_n   = offset_t'(pos - count_t'(HDR_BYTES));
				end
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= STG_IDLE;
			cnt_q   <= '0;
			len_q   <= '0;
			id_q    <= '0;
			param_q <= '0;
		end else if (advance) begin
			stage_q <= stage_n;
			cnt_q   <= cnt_n;
			len_q   <= len_n;
			id_q    <= id_n;
			param_q <= param_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q   <= kind_n;
			obyte_q  <= obyte_n;
			off_q    <= off_n;
			oid_q    <= id_q;
			oparam_q <= param_q;
			olen_q   <= len_q;
			ok_q     <= ok_n;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.item_kind      = kind_q;
	assign res.payload_byte   = obyte_q;
	assign res.payload_offset = off_q;
	assign res.message_id     = oid_q;
	assign res.message_param  = oparam_q;
	assign res.payload_length = olen_q;
	assign res.frame_ok       = ok_q;

`ifndef NO_ASSERTIONS
	// The stored count stays within the frame limit
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= count_t'(MAX_FRAME))
		else $error("stored count above frame limit");

	// Nothing is counted before the first framing byte
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == STG_IDLE |-> cnt_q == '0 && len_q == '0)
		else $error("idle parser holds frame state");

	// A good verdict is only ever given on an end item
	a_ok_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ok_q |-> kind_q == KIND_END)
		else $error("frame_ok set on a payload item");

	// A framing byte always opens a new frame with cleared header
	a_frame_open: assert property (@(posedge clk) disable iff (!arst_n)
		advance && byte_s1 == framing_q |=> stage_q == STG_OPEN && cnt_q == '0
			&& out_valid_q && kind_q == KIND_END)
		else $error("framing byte did not restart the frame");
`endif

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-stuffed frame deframer. Raw bytes go in
// over the rx channel with random gaps, and a local deframer model predicts
// every payload and verdict item. Results are taken under random back-pressure
// and compared field by field in order. Register settings change only while
// the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import bsfd_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_GAP       = 8;
	localparam int REPORT_MAX    = 10;

	// One deframed result item
	typedef struct {
		logic    kind;
		byte_t   data;
		offset_t offset;
		byte_t   msg_id;
		byte_t   param;
		length_t length;
		logic    ok;
	} deframed_t;

	logic clk;
	logic arst_n;

	bsfd_rx_if  rx ();
	bsfd_res_if res ();
	bsfd_cfg_if cfg ();

	byte_stuffed_frame_deframer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.res    (res),
		.cfg    (cfg)
	);

	// Model registers and parser state
	byte_t       reg_framing;
	byte_t       reg_escape;
	byte_t       reg_fr_code;
	byte_t       reg_esc_code;
	stage_t      m_stage;
	int unsigned m_count;
	length_t     m_length;
	byte_t       m_id;
	byte_t       m_param;

	deframed_t items_due[$];
	byte_t     tx_bytes[$];

	int gap_max = MAX_GAP;
	int cycles = 0;
	int mismatches = 0;
	int bytes_sent = 0;
	int payload_seen = 0;
	int verdicts_seen = 0;
	int good_frames = 0;
	int settings_used = 0;

	deframed_t got_item;
	deframed_t want_item;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items still due", cycles, items_due.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Deframer model: one raw byte in, zero or one item onto the due queue
	task automatic deframe_byte(input byte_t raw);
		byte_t       b;
		int unsigned pos;
		deframed_t   it;
		b = raw;
		it.kind   = KIND_END;
		it.data   = '0;
		it.offset = '0;
		it.ok     = 1'b0;
		if (b == reg_framing) begin
			if (m_count < MAX_FRAME) begin
				m_count++;
				if (m_count >= FRAME_OVERHEAD && m_count == m_length + FRAME_OVERHEAD)
					it.ok = 1'b1;
			end
			it.msg_id = m_id;
			it.param  = m_param;
			it.length = m_length;
			items_due.push_back(it);
			m_stage  = STG_OPEN;
			m_count  = 0;
			m_length = '0;
			m_id     = '0;
			m_param  = '0;
			return;
		end
		if (m_stage == STG_IDLE || m_count >= MAX_FRAME)
			return;
		// leading framing byte is stored with the first body byte
		if (m_stage == STG_OPEN)
			m_count++;
		if (m_stage == STG_ESC) begin
			if (b == reg_fr_code)
				b = reg_framing;
			else if (b == reg_esc_code)
				b = reg_escape;
			else
				return;
		end else if (b == reg_escape) begin
			m_stage = STG_ESC;
			return;
		end
		pos = m_count;
		if (m_count < MAX_FRAME)
			m_count++;
		m_stage = STG_BODY;
		case (pos)
			POS_LEN_HI: m_length[15:8] = b;
			POS_LEN_LO: m_length[7:0] = b;
			POS_MSG_ID: m_id = b;
			POS_PARAM:  m_param = b;
			default: begin
				if (pos >= HDR_BYTES) begin
					it.kind   = KIND_DATA;
					it.data   = b;
					it.offset = offset_t'(pos - HDR_BYTES);
					it.msg_id = m_id;
					it.param  = m_param;
					it.length = m_length;
					items_due.push_back(it);
				end
			end
		endcase
	endtask

	// Result sink: random stall before each transaction
	initial begin : res_sink
		int n;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(0, gap_max);
			if (n > 0) begin
				res.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			got_item.kind   = res.item_kind;
			got_item.data   = res.payload_byte;
			got_item.offset = res.payload_offset;
			got_item.msg_id = res.message_id;
			got_item.param  = res.message_param;
			got_item.length = res.payload_length;
			got_item.ok     = res.frame_ok;
			if (got_item.kind == KIND_END) begin
				verdicts_seen++;
				if (got_item.ok === 1'b1)
					good_frames++;
			end else begin
				payload_seen++;
			end
			if (items_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected item: kind %0d byte %02h off %0d ok %0d",
						got_item.kind, got_item.data, got_item.offset, got_item.ok);
			end else begin
				want_item = items_due.pop_front();
				if (got_item.kind !== want_item.kind || got_item.data !== want_item.data ||
						got_item.offset !== want_item.offset ||
						got_item.msg_id !== want_item.msg_id ||
						got_item.param !== want_item.param ||
						got_item.length !== want_item.length || got_item.ok !== want_item.ok) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("mismatch: expected kind %0d byte %02h off %0d id %02h par %02h len %04h ok %0d",
							want_item.kind, want_item.data, want_item.offset, want_item.msg_id,
							want_item.param, want_item.length, want_item.ok);
						$display("          actual   kind %0d byte %02h off %0d id %02h par %02h len %04h ok %0d",
							got_item.kind, got_item.data, got_item.offset, got_item.msg_id,
							got_item.param, got_item.length, got_item.ok);
					end
				end
			end
		end
	end

	// One rx transaction after a random gap
	task automatic send_byte(input byte_t b);
		int n;
		n = $urandom_range(0, gap_max);
		if (n > 0) begin
			rx.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		do @(posedge clk); while (!rx.ready);
		deframe_byte(b);
		bytes_sent++;
	endtask

	task automatic send_tx();
		while (tx_bytes.size() != 0)
			send_byte(tx_bytes.pop_front());
	endtask

	// Pause the sender until every due item has come, then let the pipe empty
	task automatic wait_drained();
		rx.valid <= 1'b0;
		while (items_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four registers while idle
	task automatic set_regs(input byte_t f, input byte_t e, input byte_t fc, input byte_t ec);
		byte_t    vals[4];
		cfg_reg_t regs[4];
		vals = '{f, e, fc, ec};
		regs = '{REG_FRAMING_BYTE, REG_ESCAPE_BYTE, REG_ESCAPED_FRAMING_CODE,
			REG_ESCAPED_ESCAPE_CODE};
		wait_drained();
		for (int i = 0; i < 4; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= regs[i];
			cfg.data  <= vals[i];
			do @(posedge clk); while (!cfg.ready);
			case (regs[i])
				REG_FRAMING_BYTE:         reg_framing  = vals[i];
				REG_ESCAPE_BYTE:          reg_escape   = vals[i];
				REG_ESCAPED_FRAMING_CODE: reg_fr_code  = vals[i];
				REG_ESCAPED_ESCAPE_CODE:  reg_esc_code = vals[i];
				default: ;
			endcase
		end
		cfg.valid <= 1'b0;
		settings_used++;
	endtask

	// Append a byte in stuffed form
	task automatic put_stuffed(input byte_t v);
		if (v == reg_framing) begin
			tx_bytes.push_back(reg_escape);
			tx_bytes.push_back(reg_fr_code);
		end else if (v == reg_escape) begin
			tx_bytes.push_back(reg_escape);
			tx_bytes.push_back(reg_esc_code);
		end else begin
			tx_bytes.push_back(v);
		end
	endtask

	// Random payload byte, often one that needs stuffing
	function automatic byte_t pick_payload();
		case ($urandom_range(0, 7))
			0: return reg_framing;
			1: return reg_escape;
			default: return byte_t'($urandom);
		endcase
	endfunction

	task automatic put_header(input length_t len, input byte_t id, input byte_t param);
		put_stuffed(len[15:8]);
		put_stuffed(len[7:0]);
		put_stuffed(id);
		put_stuffed(param);
	endtask

	// Header, n payload bytes, closing framing byte
	task automatic send_frame(input length_t len, input byte_t id, input byte_t param,
			input int n);
		put_header(len, id, param);
		repeat (n) put_stuffed(pick_payload());
		tx_bytes.push_back(reg_framing);
		send_tx();
	endtask

	// Idle bytes, defaults, stuffing, unknown code, early close, short frame
	task automatic test_directed_defaults();
		tx_bytes = '{8'h00, 8'hFF, RST_ESCAPE_BYTE,
			RST_FRAMING_BYTE,
			8'h00, 8'h04, 8'hA5, 8'h5A,
			8'h00, 8'hFF, RST_ESCAPE_BYTE, RST_ESCAPED_FRAMING_CODE,
			RST_ESCAPE_BYTE, RST_ESCAPED_ESCAPE_CODE,
			RST_FRAMING_BYTE,
			8'h00, 8'h01, 8'h11, 8'h22, RST_ESCAPE_BYTE, 8'h33, RST_ESCAPED_FRAMING_CODE,
			RST_FRAMING_BYTE,
			RST_ESCAPE_BYTE, RST_FRAMING_BYTE,
			8'hFF, 8'hFF, RST_FRAMING_BYTE};
		send_tx();
	endtask

	// Registers holding equal values: framing wins, then escape, then framing code
	task automatic test_equal_registers();
		set_regs(8'h40, 8'h40, 8'h41, 8'h41);
		tx_bytes = '{8'h40, 8'h00, 8'h01, 8'hAA, 8'hBB, 8'h41, 8'h40};
		send_tx();
		set_regs(8'h40, 8'h42, 8'h41, 8'h41);
		tx_bytes = '{8'h00, 8'h01, 8'hCC, 8'hDD, 8'h42, 8'h41, 8'h40};
		send_tx();
		set_regs(8'h40, 8'h42, 8'h40, 8'h42);
		tx_bytes = '{8'h00, 8'h01, 8'h11, 8'h22, 8'h42, 8'h42, 8'h42, 8'h40};
		send_tx();
	endtask

	// Frame that just fits, then one that overruns the limit
	task automatic test_frame_limit();
		set_regs(RST_FRAMING_BYTE, RST_ESCAPE_BYTE, RST_ESCAPED_FRAMING_CODE,
			RST_ESCAPED_ESCAPE_CODE);
		gap_max = 2;
		send_byte(reg_framing);
		send_frame(16'(MAX_FRAME - FRAME_OVERHEAD), 8'h3C, 8'hC3, MAX_FRAME - FRAME_OVERHEAD);
		send_frame(16'(MAX_FRAME - FRAME_OVERHEAD), 8'h81, 8'h18, MAX_FRAME + 12);
		gap_max = MAX_GAP;
	endtask

	// Mostly well-formed frames with random content, some broken ones and noise
	task automatic random_frames(input int budget);
		int    start;
		int    n;
		byte_t code;
		start = bytes_sent;
		send_byte(reg_framing);
		while (bytes_sent - start < budget) begin
			gap_max = ($urandom_range(0, 5) == 0) ? 0 : MAX_GAP;
			case ($urandom_range(0, 9))
				7: send_frame(length_t'($urandom), byte_t'($urandom), byte_t'($urandom),
					$urandom_range(0, 10));
				8: begin
					n = $urandom_range(0, 6);
					put_header(length_t'(n), byte_t'($urandom), byte_t'($urandom));
					repeat ($urandom_range(0, 3)) put_stuffed(pick_payload());
					do code = byte_t'($urandom);
					while (code == reg_fr_code || code == reg_esc_code || code == reg_framing);
					tx_bytes.push_back(reg_escape);
					tx_bytes.push_back(code);
					repeat ($urandom_range(0, 3)) put_stuffed(pick_payload());
					// sometimes an escape right before the close
					if ($urandom_range(0, 1) == 1)
						tx_bytes.push_back(reg_escape);
					tx_bytes.push_back(reg_framing);
					send_tx();
				end
				9: begin
					repeat ($urandom_range(1, 20)) tx_bytes.push_back(byte_t'($urandom));
					tx_bytes.push_back(reg_framing);
					send_tx();
				end
				default: begin
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
					send_frame(length_t'(n), byte_t'($urandom), byte_t'($urandom), n);
				end
			endcase
		end
		gap_max = MAX_GAP;
	endtask

	task automatic test_random_settings();
		byte_t v[4];
		set_regs(RST_FRAMING_BYTE, RST_ESCAPE_BYTE, RST_ESCAPED_FRAMING_CODE,
			RST_ESCAPED_ESCAPE_CODE);
		random_frames(60);
		set_regs(8'h00, 8'hFF, 8'h01, 8'h02);
		random_frames(30);
		// hold the sender until everything due has arrived
		wait_drained();
		random_frames(30);
		set_regs(8'hFF, 8'h00, 8'hFE, 8'hFD);
		random_frames(60);
		set_regs(8'h01, 8'h02, 8'h00, 8'hFF);
		random_frames(60);
		set_regs(8'h03, 8'h04, 8'hFF, 8'h00);
		random_frames(60);
		repeat (4) begin
			// four distinct values so that stuffing stays unambiguous
			v[0] = byte_t'($urandom);
			do v[1] = byte_t'($urandom); while (v[1] == v[0]);
			do v[2] = byte_t'($urandom); while (v[2] == v[0] || v[2] == v[1]);
			do v[3] = byte_t'($urandom);
			while (v[3] == v[0] || v[3] == v[1] || v[3] == v[2]);
			set_regs(v[0], v[1], v[2], v[3]);
			random_frames(60);
		end
	endtask

	// Main sequence
	initial begin
		arst_n       = 1'b0;
		rx.valid     = 1'b0;
		rx.rx_byte   = '0;
		cfg.valid    = 1'b0;
		cfg.index    = '0;
		cfg.data     = '0;
		reg_framing  = RST_FRAMING_BYTE;
		reg_escape   = RST_ESCAPE_BYTE;
		reg_fr_code  = RST_ESCAPED_FRAMING_CODE;
		reg_esc_code = RST_ESCAPED_ESCAPE_CODE;
		m_stage      = STG_IDLE;
		m_count      = 0;
		m_length     = '0;
		m_id         = '0;
		m_param      = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_equal_registers();
		test_frame_limit();
		test_random_settings();

		wait_drained();
		if (items_due.size() != 0)
			mismatches++;
		$display("%0d bytes sent under %0d register settings; %0d payload items checked",
			bytes_sent, settings_used, payload_seen);
		$display("%0d frame verdicts checked, %0d good; %0d mismatches",
			verdicts_seen, good_frames, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
